// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the divider RTL.
// Depends on nothing; every user must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/urdiv_pkg.sv
// Shared widths and stage types for the unsigned restoring divider.
// Depends on nothing.
package urdiv_pkg;

    // Width of the dividend, divisor and quotient ports.
    localparam int DATA_W = 64;
    // Datapath width; operands are cut to this many low bits (8 to 64).
    localparam int WIDTH = 64;

    typedef logic [WIDTH-1:0] word_t;

    // One division in flight: partial remainder, dividend bits still to be
    // consumed on top with quotient bits entering at the bottom, and divisor.
    typedef struct packed {
        word_t rem;
        word_t nq;
        word_t den;
    } stage_t;

endpackage

// File: hw/rtl/urdiv_cell.sv
// One cell of the divider chain: a trial subtraction and a stage register.
// Depends on urdiv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module urdiv_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    input  urdiv_pkg::stage_t up_data,
    output logic              up_ready,
    output logic              dn_valid,
    output urdiv_pkg::stage_t dn_data,
    input  logic              dn_ready
);

    logic              valid_reg;
    logic              valid_next;
    urdiv_pkg::stage_t data_reg;
    urdiv_pkg::stage_t data_next;

    logic [urdiv_pkg::WIDTH:0]   shifted;
    logic [urdiv_pkg::WIDTH+1:0] diff;
    logic                        take;

    // Shift the next dividend bit into the remainder and try the subtraction.
    always_comb
    begin
        shifted = {up_data.rem, up_data.nq[urdiv_pkg::WIDTH-1]};
        diff    = {1'b0, shifted} - {2'b00, up_data.den};
        take    = ~diff[urdiv_pkg::WIDTH+1];

        data_next.rem = take ? diff[urdiv_pkg::WIDTH-1:0] : shifted[urdiv_pkg::WIDTH-1:0];
        data_next.nq  = {up_data.nq[urdiv_pkg::WIDTH-2:0], take};
        data_next.den = up_data.den;
    end

    // The stage can take a new request when it is empty or its content moves on.
    assign up_ready   = ~valid_reg | dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    `ASSERT_NEXT(a_hold_when_blocked, valid_reg && !dn_ready,
        valid_reg && $stable(data_reg), "urdiv_cell: blocked stage lost its request")
    `ASSERT_NEXT(a_fill_on_take, up_valid && up_ready, valid_reg,
        "urdiv_cell: accepted request did not land in the stage")
    `ASSERT_SAME(a_ready_when_empty, !valid_reg, up_ready,
        "urdiv_cell: empty stage refused a request")

endmodule

// File: hw/rtl/unsigned_restoring_divider_unit.sv
// out_valid rises once an accepted request has moved through every cell in turn.
// Throughput: one request per cycle unless in_stall is high; a row of WIDTH cells,
// one per quotient bit. Stalls collapse bubbles, so the input keeps accepting
// while any cell is empty.
// Reset (rst_n, asynchronous, active low) empties every cell; data is not cleared.
// Depends on urdiv_pkg, urdiv_cell and assert_macros.svh.
`include "assert_macros.svh"

module unsigned_restoring_divider_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [urdiv_pkg::DATA_W-1:0] dividend,
    input  logic [urdiv_pkg::DATA_W-1:0] divisor,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [urdiv_pkg::DATA_W-1:0] quotient
);

    // Links between cells. Entry 0 is the input side, entry WIDTH the output side.
    // Each cell handles one quotient bit, from the top bit down, so after WIDTH
    // cells the shift register that started out holding the dividend holds the
    // complete quotient.
    logic              link_valid [urdiv_pkg::WIDTH+1];
    urdiv_pkg::stage_t link_data  [urdiv_pkg::WIDTH+1];
    logic              link_ready [urdiv_pkg::WIDTH+1];

    // A new request starts with an empty remainder. Only the low WIDTH bits of
    // each operand take part. A zero divisor makes every trial subtraction
    // succeed, which yields an all-ones quotient without any special handling.
    assign link_valid[0]    = in_valid;
    assign link_data[0].rem = '0;
    assign link_data[0].nq  = dividend[urdiv_pkg::WIDTH-1:0];
    assign link_data[0].den = divisor[urdiv_pkg::WIDTH-1:0];
    assign in_stall         = ~link_ready[0];

    genvar i;
    generate
        for (i = 0; i < urdiv_pkg::WIDTH; i++)
        begin : g_cell
            urdiv_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .up_valid (link_valid[i]),
                .up_data  (link_data[i]),
                .up_ready (link_ready[i]),
                .dn_valid (link_valid[i+1]),
                .dn_data  (link_data[i+1]),
                .dn_ready (link_ready[i+1])
            );
        end
    endgenerate

    // The last cell's register is the output register; the quotient is
    // zero-extended when the datapath is narrower than the ports.
    assign link_ready[urdiv_pkg::WIDTH] = ~out_stall;
    assign out_valid = link_valid[urdiv_pkg::WIDTH];
    assign quotient  = urdiv_pkg::DATA_W'(link_data[urdiv_pkg::WIDTH].nq);

    // The input can only be held off when the chain is full up to the output.
    `ASSERT_SAME(a_stall_needs_result, in_stall, out_valid,
        "divider: input stalled with no result waiting")
    // With the output draining, every cell can move, so the input is open.
    `ASSERT_SAME(a_open_when_draining, !out_stall, !in_stall,
        "divider: input stalled while the output is draining")
    // A result that is refused stays on the output unchanged.
    `ASSERT_NEXT(a_result_held, out_valid && out_stall, out_valid && $stable(quotient),
        "divider: refused result changed or vanished")

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for unsigned_restoring_divider_unit.
// Depends on urdiv_pkg and the divider RTL. A small scoreboard predicts each quotient and
// checks results in order while plain tasks drive requests under random gaps and stalls.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W = urdiv_pkg::DATA_W;
    localparam int WIDTH  = urdiv_pkg::WIDTH;

    // The divider is a row of WIDTH cells.
    localparam int LATENCY = WIDTH;
    // The slowest correct run is about 1700 requests plus the drain; this limit is
    // many times what that run needs.
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PER_PHASE = 550;

    typedef logic [DATA_W-1:0] data_t;
    typedef urdiv_pkg::word_t word_t;

    // One accepted request together with the quotient that it must produce.
    typedef struct {
        data_t num;
        data_t den;
        data_t quo;
    } division_t;

    // Keeps the quotients still owed by the divider, oldest first.
    class quotient_scoreboard;
        division_t owed_q[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        // Restoring division at the datapath width. The bit shifted out of the top of the
        // partial remainder is kept as a carry, so the trial subtraction is exact. A zero
        // divisor lets every trial succeed and gives all ones.
        static function data_t restoring_quotient(data_t num, data_t den);
            word_t n;
            word_t d;
            word_t rem;
            word_t quo;
            logic  carry;
            n   = num[WIDTH-1:0];
            d   = den[WIDTH-1:0];
            rem = '0;
            quo = '0;
            for (int b = WIDTH - 1; b >= 0; b--)
            begin
                carry = rem[WIDTH-1];
                rem   = {rem[WIDTH-2:0], n[b]};
                if (carry || rem >= d)
                begin
                    rem    = rem - d;
                    quo[b] = 1'b1;
                end
            end
            return data_t'(quo);
        endfunction

        function void note_request(data_t num, data_t den);
            division_t e;
            e.num = num;
            e.den = den;
            e.quo = restoring_quotient(num, den);
            owed_q.push_back(e);
        endfunction

        function void check_quotient(data_t actual);
            division_t e;
            if (owed_q.size() == 0)
            begin
                $display("%0t: unexpected quotient: expected none, actual %h", $time, actual);
                errors++;
                return;
            end
            e = owed_q.pop_front();
            if (actual !== e.quo)
            begin
                $display("%0t: quotient of %h / %h: expected %h, actual %h",
                         $time, e.num, e.den, e.quo, actual);
                errors++;
            end
        endfunction

        function int outstanding();
            return owed_q.size();
        endfunction
    endclass

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    logic  in_stall;
    data_t dividend  = '0;
    data_t divisor   = '0;
    logic  out_valid;
    logic  out_stall = 1'b0;
    data_t quotient;

    // Chance, in percent, that the sender leaves a cycle empty or the receiver stalls.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycle_count    = 0;

    quotient_scoreboard sb = new();

    unsigned_restoring_divider_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .dividend  (dividend),
        .divisor   (divisor),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .quotient  (quotient)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver. The result is taken on the values seen at the edge, and the stall for
    // the next cycle is drawn afterwards, so a stall can land on any cycle of a result.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_quotient(quotient);
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Random operand with a random number of leading zeros, so that small, medium and
    // full-width values all turn up often.
    function automatic data_t rand_word();
        data_t w;
        w = {$urandom, $urandom};
        return w >> $urandom_range(DATA_W - 1);
    endfunction

    // Drives one request and returns once the divider has taken it. Idle cycles go in
    // ahead of the request; valid is only written once per edge, so a back-to-back
    // request keeps valid high without a glitch.
    task automatic send_request(data_t num, data_t den);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        dividend <= num;
        divisor  <= den;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sb.note_request(num, den);
    endtask

    // Random request. Most pairs are unrelated random words, but the mix also favors
    // the corners: zero divisor, divisor equal to or just off the dividend, tiny
    // divisors, and divisors with the top bit set where the carry out of the partial
    // remainder decides the trial subtraction.
    task automatic send_random_request();
        data_t num;
        data_t den;
        num = rand_word();
        den = rand_word();
        case ($urandom_range(9))
            0: den = '0;
            1: den = num + data_t'($urandom_range(2)) - data_t'(1);
            2: den = data_t'($urandom_range(16, 1));
            3:
            begin
                num = {$urandom, $urandom};
                den = {$urandom, $urandom};
            end
            4:
            begin
                num = rand_word();
                num[DATA_W-1] = 1'b1;
                den = {$urandom, $urandom};
                den[WIDTH-1] = 1'b1;
            end
            5: num = den * data_t'($urandom_range(1000));
            default: ;
        endcase
        send_request(num, den);
    endtask

    task automatic run_random_phase(int unsigned idle_pct, int unsigned stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (RANDOM_PER_PHASE)
        begin
            send_random_request();
        end
    endtask

    initial
    begin
        // Reset is held once at the start and never asserted again.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct  = 38;
        recv_stall_pct = 80;

        // Directed requests: operand extremes, zero divisor, equal operands, divisor
        // larger than the dividend, and top-bit cases for the remainder carry.
        send_request('0, '0);
        send_request('1, '0);
        send_request(data_t'(1), '0);
        send_request('0, data_t'(1));
        send_request('0, '1);
        send_request('1, data_t'(1));
        send_request('1, '1);
        send_request(data_t'(1), '1);
        send_request('1, data_t'(2));
        send_request('1, '1 - data_t'(1));
        send_request('1 - data_t'(1), '1);
        send_request(data_t'(1) << (DATA_W - 1), data_t'(1));
        send_request(data_t'(1) << (DATA_W - 1), data_t'(3));
        send_request(data_t'(1) << (DATA_W - 1), (data_t'(1) << (DATA_W - 1)) + 1);
        send_request((data_t'(1) << (DATA_W - 1)) + 1, data_t'(1) << (DATA_W - 1));
        send_request({(DATA_W / 2){2'b10}}, {(DATA_W / 2){2'b01}});
        send_request({(DATA_W / 2){2'b01}}, {(DATA_W / 2){2'b10}});
        send_request(data_t'(100), data_t'(7));
        send_request(data_t'(7), data_t'(100));
        send_request(data_t'(12345), data_t'(12345));
        send_request('1, data_t'(1) << (DATA_W / 2));

        // Random requests in three idling profiles: a busy receiver, a slow sender,
        // and finally full rate with no gaps and no stalls.
        run_random_phase(38, 80);
        run_random_phase(80, 38);
        run_random_phase(0, 0);

        in_valid <= 1'b0;
        recv_stall_pct = 0;

        // Drain every owed quotient, then watch for stray results a while longer.
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (2 * LATENCY) @(posedge clk);

        if (sb.errors == 0 && sb.outstanding() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
